// ===== rtl/cartesian_to_spherical_macros.svh =====
// Assertion macros shared by the RTL of the spherical conversion block.
// Both forms sample on clock and are held off while reset is high.
`ifndef CARTESIAN_TO_SPHERICAL_MACROS_SVH
`define CARTESIAN_TO_SPHERICAL_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define C2S_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("c2s assertion failed");

// Consequent must hold in the cycle after the antecedent
`define C2S_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("c2s assertion failed");

`else

`define C2S_ASSERT_IMPLY(label, ante, cons)
`define C2S_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/c2s_pkg.sv =====
`default_nettype none

package c2s_pkg;

   // Component width and derived datapath widths
   localparam int COMP_BITS    = 16;
   localparam int SQ_BITS      = 2 * COMP_BITS;
   localparam int SCALE_SHIFT  = 60 - COMP_BITS;
   localparam int CORDIC_W     = 64;
   localparam int ANGLE_W      = 34;
   localparam int CORDIC_STEPS = 32;
   localparam int QUOT_W       = 33;
   localparam int CROOT_W      = 17;
   localparam int ANGLE_FRAC   = 17;
   localparam int AZIM_W       = 16;
   localparam int POLAR_W      = 15;
   localparam int COS_W        = 16;
   localparam int GAIN_W       = 31;
   localparam int GAIN_FRAC    = 30;

   // Constants
   localparam logic [GAIN_W-1:0]         GAIN_Q30  = 31'd1768195363;
   localparam logic signed [ANGLE_W-1:0] HALF_TURN = 34'sh0_8000_0000;
   localparam logic signed [ANGLE_W-1:0] ANG_ROUND = 34'sh0_0001_0000;
   localparam logic [POLAR_W-1:0]        ANGLE_PI  = 15'd16384;
   localparam logic signed [COS_W-1:0]   COS_ONE   = 16'sd32767;

   typedef logic signed [COMP_BITS-1:0] comp_type;

   typedef struct packed {
      comp_type comp_x;
      comp_type comp_y;
      comp_type comp_z;
   } req_type;

   typedef struct packed {
      logic [COMP_BITS-1:0]      magnitude;
      logic [COMP_BITS-1:0]      transverse;
      logic signed [AZIM_W-1:0]  azimuth;
      logic [POLAR_W-1:0]        polar;
      logic signed [COS_W-1:0]   cos_polar;
      logic                      is_zero;
   } rsp_type;

   // Vectoring rotator state handed from cell to cell
   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [ANGLE_W-1:0]  ang;
   } cordic_type;

   // Long division state handed from cell to cell
   typedef struct packed {
      logic [SQ_BITS-1:0] divisor;
      logic [SQ_BITS-1:0] rem;
      logic [QUOT_W-1:0]  quot;
   } div_type;

   // atan(2^-i) as a binary angle, 2^32 per turn
   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2FA;
         15:      val = 32'h0000517D;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A30;
         19:      val = 32'h00000518;
         20:      val = 32'h0000028C;
         21:      val = 32'h00000146;
         22:      val = 32'h000000A3;
         23:      val = 32'h00000051;
         24:      val = 32'h00000029;
         25:      val = 32'h00000014;
         26:      val = 32'h0000000A;
         27:      val = 32'h00000005;
         28:      val = 32'h00000003;
         29:      val = 32'h00000001;
         30:      val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/c2s_delay.sv =====
`default_nettype none

// Plain shift line to align side data with the long chains
module c2s_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      tap_ff[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/c2s_cordic_cell.sv =====
`default_nettype none

// One vectoring rotation step with a fixed shift
module c2s_cordic_cell #(
   parameter int SHIFT = 0
) (
   input  wire logic              clock,
   input  wire c2s_pkg::cordic_type din,
   output c2s_pkg::cordic_type    dout
);

   localparam logic signed [c2s_pkg::ANGLE_W-1:0] STEP =
      $signed({{(c2s_pkg::ANGLE_W - 32){1'b0}}, c2s_pkg::atan_entry(SHIFT)});

   logic signed [c2s_pkg::CORDIC_W-1:0] dx;
   logic signed [c2s_pkg::CORDIC_W-1:0] dy;
   c2s_pkg::cordic_type state_ff;
   c2s_pkg::cordic_type state_in;

   // rotate toward y = 0; zero residual counts as positive
   always_comb begin
      dx       = $signed(din.y) >>> SHIFT;
      dy       = $signed(din.x) >>> SHIFT;
      state_in = din;
      if (!din.y[c2s_pkg::CORDIC_W-1]) begin
         state_in.x   = din.x + dx;
         state_in.y   = din.y - dy;
         state_in.ang = din.ang + STEP;
      end else begin
         state_in.x   = din.x - dx;
         state_in.y   = din.y + dy;
         state_in.ang = din.ang - STEP;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign dout = state_ff;

endmodule

`default_nettype wire

// ===== rtl/c2s_sqrt_cell.sv =====
`default_nettype none

// One root bit of a restoring square root
module c2s_sqrt_cell #(
   parameter int RAD_W  = 32,
   parameter int ROOT_W = 16,
   parameter int BIT    = 0
) (
   input  wire logic              clock,
   input  wire logic [RAD_W-1:0]  din_rem,
   input  wire logic [ROOT_W-1:0] din_root,
   output logic      [RAD_W-1:0]  dout_rem,
   output logic      [ROOT_W-1:0] dout_root
);

   localparam int TRIAL_W = RAD_W + 2;

   logic [TRIAL_W-1:0] trial;
   logic               fits;
   logic [RAD_W-1:0]   rem_ff;
   logic [RAD_W-1:0]   rem_in;
   logic [ROOT_W-1:0]  root_ff;
   logic [ROOT_W-1:0]  root_in;

   // trial = 2*root*2^BIT + 4^BIT; root holds only bits above BIT
   always_comb begin
      trial   = (TRIAL_W'(din_root) << (BIT + 1)) | (TRIAL_W'(1) << (2 * BIT));
      fits    = TRIAL_W'(din_rem) >= trial;
      rem_in  = din_rem;
      root_in = din_root;
      if (fits) begin
         rem_in  = din_rem - trial[RAD_W-1:0];
         root_in = din_root | (ROOT_W'(1) << BIT);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dout_rem  = rem_ff;
   assign dout_root = root_ff;

endmodule

`default_nettype wire

// ===== rtl/c2s_div_cell.sv =====
`default_nettype none

// One quotient bit of the z^2 / |v|^2 long division
module c2s_div_cell (
   input  wire logic             clock,
   input  wire c2s_pkg::div_type din,
   output c2s_pkg::div_type      dout
);

   logic [c2s_pkg::SQ_BITS:0] twice;
   logic                      take;
   c2s_pkg::div_type          state_ff;
   c2s_pkg::div_type          state_in;

   // remainder stays below the divisor, so twice it fits one extra bit
   always_comb begin
      twice    = {din.rem, 1'b0};
      take     = twice >= {1'b0, din.divisor};
      state_in = din;
      state_in.quot = {din.quot[c2s_pkg::QUOT_W-2:0], take};
      if (take) begin
         state_in.rem = c2s_pkg::SQ_BITS'(twice - {1'b0, din.divisor});
      end else begin
         state_in.rem = twice[c2s_pkg::SQ_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign dout = state_ff;

endmodule

`default_nettype wire

// ===== rtl/cartesian_to_spherical.sv =====
// A vector accepted at one clock edge gives its result on rsp_data with rsp_strobe
//   high after passing the input register, rotator entry register, the two 32-cell
//   rotator chains in series and the output register.
// Throughput: one vector per cycle, every cycle; busy is always low.
// The result is held for one cycle only; the receiver cannot stall.
// Reset clears the valid pipeline: no strobe follows reset until a new transfer.
`default_nettype none

`include "cartesian_to_spherical_macros.svh"

module cartesian_to_spherical (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire c2s_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output c2s_pkg::rsp_type      rsp_data
);

   localparam int N        = c2s_pkg::COMP_BITS;
   localparam int SQ       = c2s_pkg::SQ_BITS;
   localparam int CW       = c2s_pkg::CORDIC_W;
   localparam int AW       = c2s_pkg::ANGLE_W;
   localparam int STEPS    = c2s_pkg::CORDIC_STEPS;
   localparam int QW       = c2s_pkg::QUOT_W;
   localparam int RW       = c2s_pkg::CROOT_W;
   localparam int PROD_W   = (60 - c2s_pkg::GAIN_FRAC) + c2s_pkg::GAIN_W;
   // stage numbers, stage 0 being the input register
   localparam int ST_SUM   = 2;
   localparam int ST_C1    = 1 + STEPS;
   localparam int ST_C2    = ST_C1 + STEPS;
   localparam int ST_DIV   = ST_SUM + 1 + STEPS;
   localparam int ST_CROOT = ST_DIV + RW;
   localparam int ST_OUT   = ST_C2 + 1;

   logic accept;
   logic [ST_OUT:0] vld_ff;

   // stage 0
   c2s_pkg::req_type req_ff;

   // stage 1
   logic [N-1:0]        ax, ay, az;
   logic [59:0]         az_scaled;
   logic [SQ-1:0]       ax2_ff, ay2_ff, az2_ff;
   logic [PROD_W-1:0]   gain_hi_ff, gain_lo_ff;
   logic                zneg1_ff;
   logic signed [CW-1:0] cx, cy;
   c2s_pkg::cordic_type c1_in;
   c2s_pkg::cordic_type c1_ff;

   // stage 2
   logic [SQ-1:0] p2_ff, s_ff, az2b_ff;
   logic [CW-1:0] gz_ff;
   logic          zneg2_ff;

   // stage 3
   logic             quot_top;
   c2s_pkg::div_type div_in;
   c2s_pkg::div_type div_ff;

   // chains
   c2s_pkg::cordic_type c1_pipe  [STEPS+1];
   c2s_pkg::cordic_type c2_pipe  [STEPS+1];
   c2s_pkg::div_type    div_pipe [STEPS+1];
   logic [SQ-1:0]       mag_rem   [N+1];
   logic [N-1:0]        mag_root  [N+1];
   logic [SQ-1:0]       trn_rem   [N+1];
   logic [N-1:0]        trn_root  [N+1];
   logic [QW-1:0]       cos_rem   [RW+1];
   logic [RW-1:0]       cos_root  [RW+1];

   // aligned at the last chain stage
   logic [CW-1:0]        gz_d;
   logic signed [AW-1:0] a1_d;
   logic [N-1:0]         mag_d, trn_d;
   logic [RW-1:0]        croot_d;
   logic [2:0]           flags_d;
   logic                 fin_zero, fin_p2z, fin_zneg;

   // output stage
   logic signed [AW-1:0] az_sum, pol_ang, pol_sum;
   logic [RW:0]          cos_sum;
   logic [RW-1:0]        cos_mag, cos_neg;
   c2s_pkg::rsp_type     rsp_ff;
   c2s_pkg::rsp_type     rsp_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // valid pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[ST_OUT-1:0], accept};
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_data;
   end

   // stage 1: squares, gain products, rotator entry into the right half plane
   always_comb begin
      ax = req_ff.comp_x[N-1] ? N'(-req_ff.comp_x) : N'(req_ff.comp_x);
      ay = req_ff.comp_y[N-1] ? N'(-req_ff.comp_y) : N'(req_ff.comp_y);
      az = req_ff.comp_z[N-1] ? N'(-req_ff.comp_z) : N'(req_ff.comp_z);
      az_scaled = {az, {c2s_pkg::SCALE_SHIFT{1'b0}}};
      cx = {{(CW - N){req_ff.comp_x[N-1]}}, req_ff.comp_x} << c2s_pkg::SCALE_SHIFT;
      cy = {{(CW - N){req_ff.comp_y[N-1]}}, req_ff.comp_y} << c2s_pkg::SCALE_SHIFT;
      c1_in.x   = cx;
      c1_in.y   = cy;
      c1_in.ang = '0;
      if (req_ff.comp_x[N-1]) begin
         c1_in.x   = -cx;
         c1_in.y   = -cy;
         c1_in.ang = req_ff.comp_y[N-1] ? -c2s_pkg::HALF_TURN : c2s_pkg::HALF_TURN;
      end
   end

   always_ff @(posedge clock) begin
      ax2_ff     <= SQ'(ax) * SQ'(ax);
      ay2_ff     <= SQ'(ay) * SQ'(ay);
      az2_ff     <= SQ'(az) * SQ'(az);
      gain_hi_ff <= PROD_W'(az_scaled[59:c2s_pkg::GAIN_FRAC]) * PROD_W'(c2s_pkg::GAIN_Q30);
      gain_lo_ff <= PROD_W'(az_scaled[c2s_pkg::GAIN_FRAC-1:0]) * PROD_W'(c2s_pkg::GAIN_Q30);
      zneg1_ff   <= req_ff.comp_z[N-1];
      c1_ff      <= c1_in;
   end

   // stage 2: sums and scaled |z| times the rotator gain
   always_ff @(posedge clock) begin
      p2_ff    <= ax2_ff + ay2_ff;
      s_ff     <= ax2_ff + ay2_ff + az2_ff;
      az2b_ff  <= az2_ff;
      gz_ff    <= CW'(gain_hi_ff) + CW'(gain_lo_ff >> c2s_pkg::GAIN_FRAC);
      zneg2_ff <= zneg1_ff;
   end

   // stage 3: leading quotient bit (z^2 equals |v|^2 on the z axis)
   always_comb begin
      quot_top       = az2b_ff >= s_ff;
      div_in.divisor = s_ff;
      div_in.rem     = quot_top ? (az2b_ff - s_ff) : az2b_ff;
      div_in.quot    = QW'(quot_top);
   end

   always_ff @(posedge clock) begin
      div_ff <= div_in;
   end

   // azimuth rotator, its x output carries the gain-scaled transverse length
   assign c1_pipe[0] = c1_ff;

   // polar rotator on (K*|z|, transverse)
   assign c2_pipe[0].x   = $signed(gz_d);
   assign c2_pipe[0].y   = c1_pipe[STEPS].x;
   assign c2_pipe[0].ang = '0;

   assign div_pipe[0] = div_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_rot
      c2s_cordic_cell #(.SHIFT(i)) u_c1 (
         .clock (clock),
         .din   (c1_pipe[i]),
         .dout  (c1_pipe[i+1])
      );
      c2s_cordic_cell #(.SHIFT(i)) u_c2 (
         .clock (clock),
         .din   (c2_pipe[i]),
         .dout  (c2_pipe[i+1])
      );
      c2s_div_cell u_div (
         .clock (clock),
         .din   (div_pipe[i]),
         .dout  (div_pipe[i+1])
      );
   end

   // exact floor roots of |v|^2 and x^2+y^2
   assign mag_rem[0]  = s_ff;
   assign mag_root[0] = '0;
   assign trn_rem[0]  = p2_ff;
   assign trn_root[0] = '0;

   for (genvar j = 0; j < N; j++) begin : g_root
      c2s_sqrt_cell #(.RAD_W(SQ), .ROOT_W(N), .BIT(N - 1 - j)) u_mag (
         .clock     (clock),
         .din_rem   (mag_rem[j]),
         .din_root  (mag_root[j]),
         .dout_rem  (mag_rem[j+1]),
         .dout_root (mag_root[j+1])
      );
      c2s_sqrt_cell #(.RAD_W(SQ), .ROOT_W(N), .BIT(N - 1 - j)) u_trn (
         .clock     (clock),
         .din_rem   (trn_rem[j]),
         .din_root  (trn_root[j]),
         .dout_rem  (trn_rem[j+1]),
         .dout_root (trn_root[j+1])
      );
   end

   // root of the quotient gives cos in Q1.16
   assign cos_rem[0]  = div_pipe[STEPS].quot;
   assign cos_root[0] = '0;

   for (genvar j = 0; j < RW; j++) begin : g_cos
      c2s_sqrt_cell #(.RAD_W(QW), .ROOT_W(RW), .BIT(RW - 1 - j)) u_cos (
         .clock     (clock),
         .din_rem   (cos_rem[j]),
         .din_root  (cos_root[j]),
         .dout_rem  (cos_rem[j+1]),
         .dout_root (cos_root[j+1])
      );
   end

   // alignment lines
   c2s_delay #(.WIDTH(CW), .DEPTH(ST_C1 - ST_SUM)) u_gz_dly (
      .clock (clock),
      .din   (gz_ff),
      .dout  (gz_d)
   );

   c2s_delay #(.WIDTH(AW), .DEPTH(ST_C2 - ST_C1)) u_a1_dly (
      .clock (clock),
      .din   (c1_pipe[STEPS].ang),
      .dout  (a1_d)
   );

   c2s_delay #(.WIDTH(N), .DEPTH(ST_C2 - ST_SUM - N)) u_mag_dly (
      .clock (clock),
      .din   (mag_root[N]),
      .dout  (mag_d)
   );

   c2s_delay #(.WIDTH(N), .DEPTH(ST_C2 - ST_SUM - N)) u_trn_dly (
      .clock (clock),
      .din   (trn_root[N]),
      .dout  (trn_d)
   );

   c2s_delay #(.WIDTH(RW), .DEPTH(ST_C2 - ST_CROOT)) u_cos_dly (
      .clock (clock),
      .din   (cos_root[RW]),
      .dout  (croot_d)
   );

   c2s_delay #(.WIDTH(3), .DEPTH(ST_C2 - ST_SUM)) u_flag_dly (
      .clock (clock),
      .din   ({s_ff == '0, p2_ff == '0, zneg2_ff}),
      .dout  (flags_d)
   );

   assign fin_zero = flags_d[2];
   assign fin_p2z  = flags_d[1];
   assign fin_zneg = flags_d[0];

   // output stage: angle rounding, polar clamp, cosine rounding and saturation
   always_comb begin
      az_sum  = a1_d + c2s_pkg::ANG_ROUND;
      pol_ang = fin_zneg ? (c2s_pkg::HALF_TURN - c2_pipe[STEPS].ang) : c2_pipe[STEPS].ang;
      pol_sum = pol_ang + c2s_pkg::ANG_ROUND;
      cos_sum = {1'b0, croot_d} + (RW + 1)'(1);
      cos_mag = cos_sum[RW:1];
      cos_neg = RW'(0) - cos_mag;

      rsp_in.magnitude  = mag_d;
      rsp_in.transverse = trn_d;
      rsp_in.is_zero    = fin_zero;

      if (fin_p2z) begin
         rsp_in.azimuth = '0;
      end else begin
         rsp_in.azimuth = az_sum[c2s_pkg::ANGLE_FRAC +: c2s_pkg::AZIM_W];
      end

      if (fin_zero || pol_sum[AW-1]) begin
         rsp_in.polar = '0;
      end else if (pol_sum[AW-1:c2s_pkg::ANGLE_FRAC] >
                   (AW - c2s_pkg::ANGLE_FRAC)'(c2s_pkg::ANGLE_PI)) begin
         rsp_in.polar = c2s_pkg::ANGLE_PI;
      end else begin
         rsp_in.polar = pol_sum[c2s_pkg::ANGLE_FRAC +: c2s_pkg::POLAR_W];
      end

      if (fin_zero) begin
         rsp_in.cos_polar = c2s_pkg::COS_ONE;
      end else if (fin_zneg) begin
         rsp_in.cos_polar = cos_neg[c2s_pkg::COS_W-1:0];
      end else if (cos_mag > RW'(c2s_pkg::COS_ONE)) begin
         rsp_in.cos_polar = c2s_pkg::COS_ONE;
      end else begin
         rsp_in.cos_polar = cos_mag[c2s_pkg::COS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vld_ff[ST_OUT];
   assign rsp_data   = rsp_ff;

   // checks
   `C2S_ASSERT_NEXT(a_zero_vector, vld_ff[ST_OUT-1] && fin_zero, rsp_data.is_zero && rsp_data.magnitude == '0 && rsp_data.azimuth == '0 && rsp_data.polar == '0 && rsp_data.cos_polar == c2s_pkg::COS_ONE)
   `C2S_ASSERT_IMPLY(a_mag_ge_trn, rsp_strobe, rsp_data.magnitude >= rsp_data.transverse)
   `C2S_ASSERT_IMPLY(a_axis_azim, rsp_strobe && rsp_data.transverse == '0, rsp_data.azimuth == '0)
   `C2S_ASSERT_IMPLY(a_azim_range, rsp_strobe, $signed(rsp_data.azimuth) >= -16'sd16384 && $signed(rsp_data.azimuth) <= 16'sd16384)

endmodule

`default_nettype wire

// ===== verif/tb_cartesian_to_spherical.sv =====
`default_nettype none

module tb_cartesian_to_spherical;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  RANDOM_ITEMS = 900;
   localparam int  PAUSE_AT     = 300;
   localparam int  DRAIN_CYCLES = 100;
   localparam int  CYCLE_LIMIT  = 200000;
   localparam int  SHIFT_UP     = 60 - c2s_pkg::COMP_BITS;
   localparam longint HALF_REV  = 64'sd2147483648;
   localparam longint ROUND_BIT = 64'sd65536;
   localparam bit [63:0] GAIN_K = 64'd1768195363;

   // arctangent steps as binary angles, 2^32 per turn
   localparam longint ATAN_STEP [32] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
      64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
      64'h00000001, 64'h00000000};

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   c2s_pkg::req_type req_data;
   logic             rsp_strobe;
   c2s_pkg::rsp_type rsp_data;

   c2s_pkg::req_type pending_vectors[$];
   c2s_pkg::rsp_type expected_results[$];
   logic    took;
   int      sent_count;
   int      gap_left;
   int      burst_left;
   int      error_count;
   int      checked_count;
   int      zero_count;
   int      cycle_count;

   cartesian_to_spherical DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   // integer square root, floor
   function automatic bit [63:0] floor_sqrt(input bit [63:0] n);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // vectoring rotation: returns angle, gain-scaled length in len
   function automatic longint rotate_to_axis(input longint px, input longint py,
                                             output longint len);
      longint acc;
      longint dx;
      longint dy;
      acc = 0;
      for (int i = 0; i < 32; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py >= 0) begin
            px += dx; py -= dy; acc += ATAN_STEP[i];
         end else begin
            px -= dx; py += dy; acc -= ATAN_STEP[i];
         end
      end
      len = px;
      return acc;
   endfunction

   function automatic c2s_pkg::rsp_type predict_spherical(input c2s_pkg::req_type v);
      longint    x, y, z, cx, cy, off, rk, fin, ang, azim, pol, cosv;
      bit [63:0] ax, ay, az, p2, z2, s, q, r, za;
      c2s_pkg::rsp_type o;
      x = v.comp_x; y = v.comp_y; z = v.comp_z;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      az = (z < 0) ? -z : z;
      p2 = ax * ax + ay * ay;
      z2 = az * az;
      s = p2 + z2;
      azim = 0; pol = 0; cosv = 32767;
      if (s != 0) begin
         cx = (x < 0) ? -longint'(ax << SHIFT_UP) : longint'(ax << SHIFT_UP);
         cy = (y < 0) ? -longint'(ay << SHIFT_UP) : longint'(ay << SHIFT_UP);
         off = 0;
         if (x < 0) begin
            cx = -cx; cy = -cy;
            off = (y >= 0) ? HALF_REV : -HALF_REV;
         end
         ang = off + rotate_to_axis(cx, cy, rk);
         if (p2 != 0) azim = (ang + ROUND_BIT) >>> 17;
         // |z| gets the same rotator gain as the transverse length
         za = az << SHIFT_UP;
         za = (za >> 30) * GAIN_K + (((za & ((64'd1 << 30) - 1)) * GAIN_K) >> 30);
         ang = rotate_to_axis(longint'(za), rk, fin);
         if (z < 0) ang = HALF_REV - ang;
         pol = (ang + ROUND_BIT) >>> 17;
         if (pol < 0) pol = 0;
         if (pol > 16384) pol = 16384;
         // cosine squared as a 32-bit fraction, then root
         q = (z2 >= s) ? 1 : 0;
         r = z2 - q * s;
         for (int i = 0; i < 32; i++) begin
            q = q << 1;
            if (r >= s - r) begin
               r = r - (s - r);
               q = q | 1;
            end else begin
               r = r << 1;
            end
         end
         q = (floor_sqrt(q) + 1) >> 1;
         if (z >= 0) cosv = (q > 32767) ? 32767 : longint'(q);
         else cosv = -longint'(q);
      end
      o.magnitude  = floor_sqrt(s);
      o.transverse = floor_sqrt(p2);
      o.azimuth    = azim[c2s_pkg::AZIM_W-1:0];
      o.polar      = pol[c2s_pkg::POLAR_W-1:0];
      o.cos_polar  = cosv[c2s_pkg::COS_W-1:0];
      o.is_zero    = (s == 0);
      return o;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("error at %0t: %s got %0d, expected %0d", $realtime, field, got, want);
      error_count++;
   endtask

   task automatic queue_vector(input int x, input int y, input int z);
      c2s_pkg::req_type v;
      v.comp_x = x; v.comp_y = y; v.comp_z = z;
      pending_vectors.push_back(v);
   endtask

   function automatic int random_component(input int kind);
      case (kind)
         0: return $urandom_range(0, 65535) - 32768;
         1: return $urandom_range(0, 40) - 20;
         2: return 0;
         default: return ($urandom_range(0, 1) ? 32767 : -32768) - $urandom_range(0, 3) + 1;
      endcase
   endfunction

   // transfer and result monitor
   always @(posedge clock) begin
      c2s_pkg::rsp_type want;
      if (reset) begin
         took <= 1'b0;
      end else begin
         took <= start && !busy;
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", 1, 0);
            end else begin
               want = expected_results.pop_front();
               checked_count++;
               if (rsp_data.magnitude != want.magnitude)
                  report_mismatch("magnitude", rsp_data.magnitude, want.magnitude);
               if (rsp_data.transverse != want.transverse)
                  report_mismatch("transverse", rsp_data.transverse, want.transverse);
               if (rsp_data.azimuth != want.azimuth)
                  report_mismatch("azimuth", rsp_data.azimuth, want.azimuth);
               if (rsp_data.polar != want.polar)
                  report_mismatch("polar", rsp_data.polar, want.polar);
               if (rsp_data.cos_polar != want.cos_polar)
                  report_mismatch("cos_polar", rsp_data.cos_polar, want.cos_polar);
               if (rsp_data.is_zero != want.is_zero)
                  report_mismatch("is_zero", rsp_data.is_zero, want.is_zero);
            end
         end
         if (start && !busy) begin
            want = predict_spherical(req_data);
            if (want.is_zero) zero_count++;
            expected_results.push_back(want);
         end
      end
   end

   // burst driver, one pause until all results are back
   always @(negedge clock) begin
      logic free;
      if (!reset) begin
         free = !start || took;
         if (took) sent_count++;
         if (free) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_vectors.size() == 0 ||
                         (sent_count == PAUSE_AT && expected_results.size() != 0)) begin
               start <= 1'b0;
            end else begin
               req_data <= pending_vectors.pop_front();
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("cartesian_to_spherical: mismatch");
         $finish;
      end
   end

   initial begin
      int kx, ky, kz;
      clock = 0; reset = 1; start = 0; req_data = '0; took = 0;
      sent_count = 0; gap_left = 0; burst_left = 1; error_count = 0;
      checked_count = 0; zero_count = 0; cycle_count = 0;

      // directed: zero vector, axes, extremes, cosine of one and minus one
      queue_vector(0, 0, 0);
      queue_vector(0, 0, 1);
      queue_vector(0, 0, -1);
      queue_vector(0, 0, 32767);
      queue_vector(0, 0, -32768);
      queue_vector(1, 0, 0);
      queue_vector(-1, 0, 0);
      queue_vector(-32768, 0, 0);
      queue_vector(0, 32767, 0);
      queue_vector(0, -32768, 0);
      queue_vector(-5, 0, 7);
      queue_vector(-32768, -1, 0);
      queue_vector(-32768, -32768, -32768);
      queue_vector(32767, 32767, 32767);
      queue_vector(-32768, 32767, -32768);
      queue_vector(32767, -32768, 32767);
      queue_vector(1, 1, 1);
      queue_vector(-1, -1, -1);
      queue_vector(3, -4, 0);
      queue_vector(0, 0, 0);
      queue_vector(1, 0, 32767);
      queue_vector(0, -1, -32768);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kx = $urandom_range(0, 9); ky = $urandom_range(0, 9); kz = $urandom_range(0, 9);
         kx = (kx < 6) ? 0 : kx - 5; ky = (ky < 6) ? 0 : ky - 5; kz = (kz < 6) ? 0 : kz - 5;
         queue_vector(random_component(kx), random_component(ky), random_component(kz));
      end

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      wait (pending_vectors.size() == 0);
      @(negedge clock);
      while (start) @(negedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d results, %0d of them zero vectors, with axes and extremes",
               checked_count, zero_count);
      if (error_count == 0 && expected_results.size() == 0)
         $display("cartesian_to_spherical: match");
      else
         $display("cartesian_to_spherical: mismatch");
      $finish;
   end

endmodule

`default_nettype wire
